[rtl/core/line_wildcard_matcher_top_defines.svh]
// Assertion macros for the line wildcard matcher.
// Included by line_wildcard_matcher_top; expects clk_i and rst_ni in scope.
`ifndef LINE_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define LINE_WILDCARD_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define LWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lwm_pkg.sv]
// Shared types, constants and helpers of the line wildcard matcher.
// No dependencies; imported by line_wildcard_matcher_top.
package lwm_pkg;

  // Pattern store size and derived widths
  localparam int unsigned MaxSymbols = 64;
  localparam int unsigned LenW       = $clog2(MaxSymbols + 1);
  localparam int unsigned IdxW       = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;

  // Special symbols
  localparam logic [7:0] SymStar     = 8'h2A;
  localparam logic [7:0] SymQuestion = 8'h3F;
  localparam logic [7:0] SymCr       = 8'h0D;
  localparam logic [7:0] SymLf       = 8'h0A;
  localparam logic [7:0] SymNul      = 8'h00;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2
  } mode_e;

  // Pattern status codes (also the fault register encoding)
  typedef enum logic [1:0] {
    STATUS_READY    = 2'd0,
    STATUS_BAD_MASK = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  function automatic logic is_line_end(input logic [7:0] sym);
    return (sym == SymCr) || (sym == SymLf) || (sym == SymNul);
  endfunction

endpackage

[rtl/core/line_wildcard_matcher_top.sv]
// Line wildcard matcher: pattern store, position vector and result buffer.
// Depends on lwm_pkg and line_wildcard_matcher_top_defines.svh.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries requests of
// three kinds in mode_i: clear the pattern, append one pattern symbol, or a
// text byte. Star matches any run, question mark one byte, other bytes
// themselves. A text CR, LF or NUL ends a line and yields one result on the
// output channel (out_valid_o / out_stall_i): matched_o and
// pattern_status_o. No other request yields a result; mode 3 is ignored.
// Throughput: one request per cycle while in_stall_o is low. The whole
// position-vector update is combinational logic across the pattern store,
// between the state registers.
// Result: an accepted line end is registered into the output or skid register.
// Stall: results sit in an output register backed by one skid register, so
// requests keep flowing while a result waits; in_stall_o rises only once
// the skid register also holds a result.
// Reset: empty pattern, no fault, line restarted, output empty. The symbol
// store itself is not cleared; only entries below the length are used.
`include "line_wildcard_matcher_top_defines.svh"

module line_wildcard_matcher_top
  import lwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic [1:0] pattern_status_o
);

  // Pattern state
  logic [7:0]          sym_mem [MaxSymbols];
  logic [LenW-1:0]     len_q, len_d;
  logic [MaxSymbols:0] active_q, active_d;
  logic                prev_star_q, prev_star_d;
  logic                star0_q, star0_d;
  status_e             fault_q, fault_d;

  // Output register and skid register
  logic    out_valid_q, skid_valid_q;
  logic    out_match_q, skid_match_q;
  status_e out_status_q, skid_status_q;

  logic    accept;
  logic    line_end;
  logic    res_valid;
  logic    res_match;
  status_e res_status;
  logic    store_en;
  logic    out_take;

  logic [MaxSymbols:0] stay_vec, adv_vec, next_vec, closed_vec;

  assign accept   = in_valid_i && !in_stall_o;
  assign line_end = is_line_end(symbol_i);
  assign out_take = out_valid_q && !out_stall_i;

  // Current status and line result
  always_comb begin
    if (fault_q != STATUS_READY) begin
      res_status = fault_q;
    end else if (len_q == '0) begin
      res_status = STATUS_BAD_MASK;
    end else begin
      res_status = STATUS_READY;
    end
    res_match = (res_status == STATUS_READY) && active_q[len_q];
  end

  assign res_valid = accept && (mode_i == MODE_TEXT) && line_end;

  // One-byte advance of the position vector, then one star closure step.
  // Adjacent stored stars only occur with a bad mask, where the vector is
  // never reported, so a single closure level suffices.
  always_comb begin
    logic pos_ok;
    logic is_star;
    stay_vec = '0;
    adv_vec  = '0;
    for (int i = 0; i < MaxSymbols; i++) begin
      pos_ok  = (LenW'(i) < len_q) && active_q[i];
      is_star = (sym_mem[i] == SymStar);
      stay_vec[i]   = pos_ok && is_star;
      adv_vec[i+1]  = pos_ok && !is_star &&
                      ((sym_mem[i] == SymQuestion) || (sym_mem[i] == symbol_i));
    end
    next_vec   = stay_vec | adv_vec;
    closed_vec = next_vec;
    for (int i = 0; i < MaxSymbols; i++) begin
      if (next_vec[i] && (LenW'(i) < len_q) && (sym_mem[i] == SymStar)) begin
        closed_vec[i+1] = 1'b1;
      end
    end
  end

  // Pattern and line state update
  always_comb begin
    len_d       = len_q;
    prev_star_d = prev_star_q;
    star0_d     = star0_q;
    fault_d     = fault_q;
    active_d    = active_q;
    store_en    = 1'b0;
    if (accept) begin
      case (mode_e'(mode_i))
        MODE_CLEAR: begin
          len_d       = '0;
          prev_star_d = 1'b0;
          star0_d     = 1'b0;
          fault_d     = STATUS_READY;
        end
        MODE_APPEND: begin
          if (line_end) begin
            fault_d     = STATUS_BAD_MASK;
            prev_star_d = 1'b0;
          end else if (!((symbol_i == SymStar) && prev_star_q)) begin
            prev_star_d = (symbol_i == SymStar);
            if (len_q >= LenW'(MaxSymbols)) begin
              if (fault_q != STATUS_BAD_MASK) begin
                fault_d = STATUS_TOO_LONG;
              end
            end else begin
              store_en = 1'b1;
              len_d    = len_q + LenW'(1);
              if (len_q == '0) begin
                star0_d = (symbol_i == SymStar);
              end
            end
          end
        end
        MODE_TEXT: begin
          if (!line_end) begin
            active_d = closed_vec;
          end
        end
        default: begin
        end
      endcase
      // Every clear, append and line end restarts the line
      if ((mode_i == MODE_CLEAR) || (mode_i == MODE_APPEND) ||
          ((mode_i == MODE_TEXT) && line_end)) begin
        active_d    = '0;
        active_d[0] = 1'b1;
        active_d[1] = star0_d;
      end
    end
  end

  // Symbol store: one write port, no reset
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      sym_mem[len_q[IdxW-1:0]] <= symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      active_q    <= (MaxSymbols + 1)'(1);
      prev_star_q <= 1'b0;
      star0_q     <= 1'b0;
      fault_q     <= STATUS_READY;
    end else begin
      len_q       <= len_d;
      active_q    <= active_d;
      prev_star_q <= prev_star_d;
      star0_q     <= star0_d;
      fault_q     <= fault_d;
    end
  end

  // Result buffer: output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payloads
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_match_q  <= skid_match_q;
        out_status_q <= skid_status_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_match_q  <= res_match;
        skid_status_q <= res_status;
      end else begin
        out_match_q  <= res_match;
        out_status_q <= res_status;
      end
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign matched_o        = out_match_q;
  assign pattern_status_o = out_status_q;

  // Checks
  `LWM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q,
    "skid register holds a result while the output register is empty")
  `LWM_ASSERT_NOW(a_match_needs_ready, out_valid_o && matched_o,
    pattern_status_o == STATUS_READY, "match reported with a pattern fault")
  `LWM_ASSERT_NOW(a_len_in_range, 1'b1, len_q <= LenW'(MaxSymbols),
    "pattern length beyond the store size")
  `LWM_ASSERT_NEXT(a_stalled_result_kept, res_valid && out_valid_q && out_stall_i,
    skid_valid_q, "result lost while the output was stalled")

endmodule

[verif/tb.sv]
// Testbench for line_wildcard_matcher_top: directed and random requests,
// with a request-level matcher model that checks every line result in order.
// Depends on lwm_pkg and the matcher RTL only.
`timescale 1ns / 100ps

module tb;
  import lwm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned IdlePct    = 38;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] sym;
    logic       hold;   // wait for all line results before sending
  } req_t;

  typedef struct packed {
    logic    matched;
    status_e status;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode_i = MODE_CLEAR;
  logic [7:0] symbol_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       matched_o;
  logic [1:0] pattern_status_o;

  req_t     req_q[$];
  verdict_t line_verdicts_q[$];
  logic     req_taken = 1'b0;
  int       queued_cnt = 0;
  int       sent_cnt = 0;
  int       err_cnt = 0;
  int       lines_seen = 0;
  int       hit_cnt = 0;
  int       fault_cnt = 0;

  // Matcher model state
  logic [7:0]          pat_mem [MaxSymbols];
  int unsigned         pat_len = 0;
  logic [MaxSymbols:0] live_pos = (MaxSymbols + 1)'(1);
  logic                star_run = 1'b0;
  status_e             mask_err = STATUS_READY;

  line_wildcard_matcher_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .symbol_i         (symbol_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .pattern_status_o (pattern_status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic ends_line(input logic [7:0] s);
    return s == SymCr || s == SymLf || s == SymNul;
  endfunction

  // An active star also activates the position after it
  function automatic logic [MaxSymbols:0] spread_stars(input logic [MaxSymbols:0] v);
    logic [MaxSymbols:0] r;
    r = v;
    for (int i = 0; i < MaxSymbols; i++) begin
      if (i < pat_len && r[i] && pat_mem[i] == SymStar) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  // Track one accepted request; queue the line verdict at a text line end
  task automatic advance_matcher(input logic [1:0] mode, input logic [7:0] sym);
    logic [MaxSymbols:0] nxt;
    verdict_t v;
    case (mode)
      MODE_CLEAR: begin
        pat_len  = 0;
        star_run = 1'b0;
        mask_err = STATUS_READY;
        live_pos = spread_stars((MaxSymbols + 1)'(1));
      end
      MODE_APPEND: begin
        if (ends_line(sym)) begin
          mask_err = STATUS_BAD_MASK;
          star_run = 1'b0;
        end else if (!(sym == SymStar && star_run)) begin
          star_run = (sym == SymStar);
          if (pat_len >= MaxSymbols) begin
            if (mask_err != STATUS_BAD_MASK) mask_err = STATUS_TOO_LONG;
          end else begin
            pat_mem[pat_len] = sym;
            pat_len++;
          end
        end
        live_pos = spread_stars((MaxSymbols + 1)'(1));
      end
      MODE_TEXT: begin
        if (!ends_line(sym)) begin
          nxt = '0;
          for (int i = 0; i < MaxSymbols; i++) begin
            if (i < pat_len && live_pos[i]) begin
              if (pat_mem[i] == SymStar) nxt[i] = 1'b1;
              else if (pat_mem[i] == SymQuestion || pat_mem[i] == sym) nxt[i+1] = 1'b1;
            end
          end
          live_pos = spread_stars(nxt);
        end else begin
          if (mask_err != STATUS_READY) v.status = mask_err;
          else if (pat_len == 0) v.status = STATUS_BAD_MASK;
          else v.status = STATUS_READY;
          v.matched = (v.status == STATUS_READY) && live_pos[pat_len];
          line_verdicts_q.push_back(v);
          live_pos = spread_stars((MaxSymbols + 1)'(1));
        end
      end
      default: begin
      end
    endcase
  endtask

  // Driver: requests and output stall change on the falling edge
  always @(negedge clk_i) begin
    logic calm;
    calm = sent_cnt >= 500 && sent_cnt < 750;
    if (rst_ni) begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
      if (!in_valid_i || req_taken) begin
        if (req_q.size() != 0 && !(req_q[0].hold && line_verdicts_q.size() != 0) &&
            (calm || $urandom_range(99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          mode_i     <= req_q[0].mode;
          symbol_i   <= req_q[0].sym;
          void'(req_q.pop_front());
          sent_cnt++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results first, then feed the accepted request to the model
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      req_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (line_verdicts_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got matched=%0b status=%0d",
                   $time, matched_o, pattern_status_o);
          err_cnt++;
        end else begin
          exp_v = line_verdicts_q.pop_front();
          if (matched_o !== exp_v.matched) begin
            $display("%0t: matched mismatch, expected %0b, got %0b",
                     $time, exp_v.matched, matched_o);
            err_cnt++;
          end
          if (pattern_status_o !== exp_v.status) begin
            $display("%0t: pattern_status mismatch, expected %0d, got %0d",
                     $time, exp_v.status, pattern_status_o);
            err_cnt++;
          end
          lines_seen++;
          if (exp_v.matched) hit_cnt++;
          if (exp_v.status != STATUS_READY) fault_cnt++;
        end
      end
      if (in_valid_i && !in_stall_o) advance_matcher(mode_i, symbol_i);
    end
  end

  task automatic push_req(input logic [1:0] mode, input logic [7:0] sym,
                          input logic hold = 1'b0);
    req_t r;
    r.mode = mode;
    r.sym  = sym;
    r.hold = hold;
    req_q.push_back(r);
    if (mode != MODE_UNUSED) queued_cnt++;
  endtask

  // Mostly a small alphabet so lines tend to match; sometimes any non-terminator
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
    else b = 8'h61 + 8'($urandom_range(2));
    if (ends_line(b)) b = 8'hFF;
    return b;
  endfunction

  function automatic logic [7:0] any_eol();
    case ($urandom_range(2))
      0:       return SymCr;
      1:       return SymLf;
      default: return SymNul;
    endcase
  endfunction

  // Clear, load a pattern, then send lines built to fit it, some broken
  task automatic gen_session(input int sess);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    logic [7:0] s;
    int len, lines, r;
    push_req(MODE_CLEAR, 8'($urandom_range(255)), (sess % 20) == 5);
    r = $urandom_range(11);
    if (r == 0) len = $urandom_range(60, 70);
    else if (r == 1) len = 0;
    else len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 22) s = SymStar;
      else if (r < 36) s = SymQuestion;
      else if (r < 38) s = any_eol();
      else s = plain_byte();
      push_req(MODE_APPEND, s);
      if (!ends_line(s)) pat.push_back(s);
    end
    lines = $urandom_range(1, 4);
    for (int n = 0; n < lines; n++) begin
      txt.delete();
      foreach (pat[k]) begin
        if (pat[k] == SymStar) repeat ($urandom_range(3)) txt.push_back(plain_byte());
        else if (pat[k] == SymQuestion) txt.push_back(plain_byte());
        else txt.push_back(pat[k]);
      end
      r = $urandom_range(9);
      if (r == 0 && txt.size() != 0) txt[$urandom_range(txt.size() - 1)] = plain_byte();
      else if (r == 1 && txt.size() != 0) void'(txt.pop_back());
      else if (r == 2) txt.push_back(plain_byte());
      else if (r == 3) begin
        // raw noise, may hold extra line ends
        txt.delete();
        repeat ($urandom_range(6)) txt.push_back(8'($urandom_range(255)));
      end
      foreach (txt[k]) push_req(MODE_TEXT, txt[k]);
      push_req(MODE_TEXT, any_eol());
      if ($urandom_range(9) == 0) push_req(MODE_TEXT, SymLf);
      r = $urandom_range(19);
      if (r == 0) push_req(MODE_UNUSED, 8'($urandom_range(255)));
      else if (r == 1) begin
        // append between lines
        s = plain_byte();
        push_req(MODE_APPEND, s);
        pat.push_back(s);
      end
    end
  endtask

  initial begin
    int sess;
    // Directed: empty pattern, star runs, question mark, byte extremes
    push_req(MODE_TEXT, SymLf);
    push_req(MODE_APPEND, 8'h61);
    push_req(MODE_APPEND, SymStar);
    push_req(MODE_APPEND, SymStar);
    push_req(MODE_APPEND, SymQuestion);
    push_req(MODE_APPEND, 8'hFF);
    push_req(MODE_TEXT, 8'h61);
    push_req(MODE_TEXT, 8'h78);
    push_req(MODE_TEXT, 8'hFF);
    push_req(MODE_TEXT, SymCr);
    push_req(MODE_TEXT, SymLf);
    push_req(MODE_UNUSED, 8'hFF);
    push_req(MODE_TEXT, 8'h61);
    push_req(MODE_TEXT, 8'hFF);
    push_req(MODE_TEXT, SymNul);
    // line end in the pattern, then bad mask holds over further appends
    push_req(MODE_APPEND, SymNul);
    push_req(MODE_TEXT, 8'h61);
    push_req(MODE_TEXT, SymLf);
    push_req(MODE_APPEND, 8'h62);
    push_req(MODE_TEXT, SymCr);
    // lone star matches an empty line
    push_req(MODE_CLEAR, 8'h00);
    push_req(MODE_APPEND, SymStar);
    push_req(MODE_TEXT, SymCr);

    sess = 0;
    while (queued_cnt < 1200) begin
      gen_session(sess);
      sess++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (line_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests in %0d pattern sessions; checked %0d line results,",
             sent_cnt, sess, lines_seen);
    $display("%0d of them matches and %0d with a pattern fault.", hit_cnt, fault_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
